// File: rtl/core/text_range_sort_merge_macros.svh
// ----------------------------------------------------------------------------
// text_range_sort_merge_macros : assertion macros for the range sort block
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_RANGE_SORT_MERGE_MACROS_SVH
`define TEXT_RANGE_SORT_MERGE_MACROS_SVH

// same-cycle implication
`define TRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg : shared types and helpers for the text range sort/merge block
// Position and range types, item structs, control struct and compare functions.
// ----------------------------------------------------------------------------
package trs_pkg;

	localparam int MAX_RANGES = 64;
	localparam int LINE_BITS  = 24;
	localparam int COL_BITS   = 16;
	localparam int POS_BITS   = LINE_BITS + COL_BITS;
	localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);

	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	typedef struct packed {
		pos_t s;
		pos_t e;
	} rng_t;

	typedef struct packed {
		logic [LINE_BITS-1:0] start_line;
		logic [COL_BITS-1:0]  start_col;
		logic [LINE_BITS-1:0] end_line;
		logic [COL_BITS-1:0]  end_col;
		logic                 last_in;
	} in_item_t;

	typedef struct packed {
		logic [LINE_BITS-1:0] out_start_line;
		logic [COL_BITS-1:0]  out_start_col;
		logic [LINE_BITS-1:0] out_end_line;
		logic [COL_BITS-1:0]  out_end_col;
		logic                 last_out;
		logic                 any_merged;
		logic                 overflow;
	} out_item_t;

	// control broadcast along the row of cells
	typedef struct packed {
		logic ins;
		logic shift;
		logic app;
		logic presorted;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_MERGE,
		ST_FLUSH,
		ST_EMIT
	} state_t;

	function automatic logic range_less(input rng_t a, input rng_t b);
		if (a.s != b.s)
			return a.s < b.s;
		return a.e < b.e;
	endfunction

	function automatic logic absorbs(input rng_t c, input rng_t b);
		logic inter, holds, held;
		inter = (b.s <= c.e) && (b.e >= c.s);
		holds = (b.s >= c.s) && (b.e <= c.e);
		held  = (c.s >= b.s) && (c.e <= b.e);
		return inter || holds || held;
	endfunction

endpackage

// File: rtl/core/trs_cell.sv
// ----------------------------------------------------------------------------
// trs_cell : one slot of the range row
// Holds one range; inserts in sorted order, shifts left, or takes an append.
// ----------------------------------------------------------------------------
module trs_cell import trs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  rng_t      new_rng,
	input  logic      first,
	input  logic      left_valid,
	input  logic      left_gt,
	input  rng_t      left_rng,
	input  logic      right_valid,
	input  rng_t      right_rng,
	output rng_t      rng,
	output logic      valid,
	output logic      gt
);

	rng_t rng_q;
	logic valid_q;
	rng_t rng_d;
	logic valid_d;

	// new item sorts ahead of what this cell holds
	assign gt = valid_q && !ctl.presorted && range_less(new_rng, rng_q);

	always_comb begin
		rng_d   = rng_q;
		valid_d = valid_q;
		if (ctl.ins) begin
			if (left_gt) begin
				rng_d   = left_rng;
				valid_d = 1'b1;
			end else if (gt || (!valid_q && (first || left_valid))) begin
				rng_d   = new_rng;
				valid_d = 1'b1;
			end
		end else if (ctl.shift) begin
			rng_d   = right_rng;
			valid_d = right_valid;
			if (ctl.app && !right_valid && (first || valid_q)) begin
				rng_d   = new_rng;
				valid_d = 1'b1;
			end
		end else if (ctl.app && !valid_q && (first || left_valid)) begin
			rng_d   = new_rng;
			valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rng_q <= rng_d;
	end

	assign rng   = rng_q;
	assign valid = valid_q;

endmodule

// File: rtl/core/trs_merge.sv
// ----------------------------------------------------------------------------
// trs_merge : dedup and merge accumulator
// Takes sorted ranges one a cycle while step is high; hands back each finished merged range.
// ----------------------------------------------------------------------------
module trs_merge import trs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic step,
	input  rng_t b,
	input  logic flush,
	output logic app,
	output rng_t app_rng,
	output logic merged
);

	rng_t acc_q, prev_q;
	logic accv_q, merged_q;
	rng_t acc_d, prev_d;
	logic accv_d, merged_d;
	pos_t lo, hi, cmin, cmax, bmin, bmax;

	always_comb begin
		cmin = (acc_q.s < acc_q.e) ? acc_q.s : acc_q.e;
		cmax = (acc_q.s > acc_q.e) ? acc_q.s : acc_q.e;
		bmin = (b.s < b.e) ? b.s : b.e;
		bmax = (b.s > b.e) ? b.s : b.e;
		lo   = (cmin < bmin) ? cmin : bmin;
		hi   = (cmax > bmax) ? cmax : bmax;
	end

	always_comb begin
		acc_d    = acc_q;
		prev_d   = prev_q;
		accv_d   = accv_q;
		merged_d = merged_q;
		app      = 1'b0;
		app_rng  = acc_q;
		if (clr) begin
			accv_d   = 1'b0;
			merged_d = 1'b0;
		end else if (flush) begin
			app    = accv_q;
			accv_d = 1'b0;
		end else if (step) begin
			if (!accv_q) begin
				acc_d  = b;
				prev_d = b;
				accv_d = 1'b1;
			end else if (b == prev_q) begin
				// exact duplicate of the last raw range
				merged_d = 1'b1;
			end else if (absorbs(acc_q, b)) begin
				// orientation follows the absorbing range
				if (acc_q.s <= acc_q.e) begin
					acc_d.s = lo;
					acc_d.e = hi;
				end else begin
					acc_d.s = hi;
					acc_d.e = lo;
				end
				prev_d   = b;
				merged_d = 1'b1;
			end else begin
				app    = 1'b1;
				acc_d  = b;
				prev_d = b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accv_q   <= 1'b0;
			merged_q <= 1'b0;
		end else begin
			accv_q   <= accv_d;
			merged_q <= merged_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q  <= acc_d;
		prev_q <= prev_d;
	end

	assign merged = merged_q;

endmodule

// File: rtl/core/text_range_sort_merge.sv
// ----------------------------------------------------------------------------
// text_range_sort_merge : sort, dedup and merge a set of text ranges
// Row of insertion cells feeding a merge accumulator, results read from the row.
// ----------------------------------------------------------------------------
// Usage: drive item and raise start; an item is taken at a clock edge with
// start high and busy low. Ranges load at one per cycle into a row of
// MAX_RANGES cells that keeps them sorted as they arrive (or in arrival order
// when presorted is set through cfg_we/cfg_wdata). Ranges past a full row are
// dropped and flagged as overflow. The item with last_in set closes the set
// and raises busy.
// For a set of n stored ranges the block then pops the row through the merge
// accumulator (results go back into the tail of the row), passes through the
// flush state, and delivers the m surviving ranges, one per cycle with strobe
// high; last_out marks the final one. busy drops after the last result.
// Results are held for one cycle only; the receiver cannot stall them.
// Reset clears the row, the counters and the presorted bit.
// ----------------------------------------------------------------------------
module text_range_sort_merge import trs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      strobe,
	output out_item_t result,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	`include "text_range_sort_merge_macros.svh"

	state_t state_q, state_d;
	logic   presorted_q;
	cnt_t   cnt_q, raw_q, res_q;
	logic   ovf_q;
	logic   accept, full;

	cell_ctl_t ctl;
	rng_t      bus_rng, in_rng, app_rng;
	logic      app, merged, m_clr, m_step, m_flush;

	rng_t rng_w [MAX_RANGES];
	logic valid_w [MAX_RANGES];
	logic gt_w [MAX_RANGES];

	assign in_rng.s = {item.start_line, item.start_col};
	assign in_rng.e = {item.end_line, item.end_col};
	assign busy     = (state_q != ST_LOAD);
	assign accept   = start && !busy;
	assign full     = (cnt_q == CNT_BITS'(MAX_RANGES));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (accept && item.last_in) state_d = ST_MERGE;
			ST_MERGE: if (raw_q == CNT_BITS'(1)) state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_EMIT;
			ST_EMIT:  if (res_q == CNT_BITS'(1)) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctl.ins       = 1'b0;
		ctl.shift     = 1'b0;
		ctl.app       = app;
		ctl.presorted = presorted_q;
		m_clr         = 1'b0;
		m_step        = 1'b0;
		m_flush       = 1'b0;
		strobe        = 1'b0;
		case (state_q)
			ST_LOAD: begin
				ctl.ins = accept && !full;
				m_clr   = accept && item.last_in;
			end
			ST_MERGE: begin
				ctl.shift = 1'b1;
				m_step    = 1'b1;
			end
			ST_FLUSH: begin
				m_flush = 1'b1;
			end
			ST_EMIT: begin
				ctl.shift = 1'b1;
				strobe    = 1'b1;
			end
			default: begin
				ctl.ins = 1'b0;
			end
		endcase
	end

	assign bus_rng  = (state_q == ST_LOAD) ? in_rng : app_rng;

	generate
		for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
			logic lv, lg, rv;
			rng_t lr, rr;
			if (i == 0) begin : g_head
				assign lv = 1'b1;
				assign lg = 1'b0;
				assign lr = '0;
			end else begin : g_body
				assign lv = valid_w[i-1];
				assign lg = gt_w[i-1];
				assign lr = rng_w[i-1];
			end
			if (i == MAX_RANGES - 1) begin : g_tail
				assign rv = 1'b0;
				assign rr = '0;
			end else begin : g_mid
				assign rv = valid_w[i+1];
				assign rr = rng_w[i+1];
			end
			trs_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.new_rng     (bus_rng),
				.first       (i == 0),
				.left_valid  (lv),
				.left_gt     (lg),
				.left_rng    (lr),
				.right_valid (rv),
				.right_rng   (rr),
				.rng         (rng_w[i]),
				.valid       (valid_w[i]),
				.gt          (gt_w[i])
			);
		end
	endgenerate

	trs_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (m_clr),
		.step    (m_step),
		.b       (rng_w[0]),
		.flush   (m_flush),
		.app     (app),
		.app_rng (app_rng),
		.merged  (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			presorted_q <= 1'b0;
			cnt_q       <= '0;
			raw_q       <= '0;
			res_q       <= '0;
			ovf_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				presorted_q <= cfg_wdata;
			if (accept) begin
				if (full)
					ovf_q <= 1'b1;
				if (item.last_in) begin
					raw_q <= full ? cnt_q : cnt_q + CNT_BITS'(1);
					cnt_q <= '0;
				end else if (!full) begin
					cnt_q <= cnt_q + CNT_BITS'(1);
				end
			end
			if (state_q == ST_MERGE)
				raw_q <= raw_q - CNT_BITS'(1);
			if (m_clr)
				res_q <= '0;
			else if (app)
				res_q <= res_q + CNT_BITS'(1);
			else if (state_q == ST_EMIT)
				res_q <= res_q - CNT_BITS'(1);
			if (state_q == ST_EMIT && res_q == CNT_BITS'(1))
				ovf_q <= 1'b0;
		end
	end

	assign result.out_start_line = rng_w[0].s[POS_BITS-1:COL_BITS];
	assign result.out_start_col  = rng_w[0].s[COL_BITS-1:0];
	assign result.out_end_line   = rng_w[0].e[POS_BITS-1:COL_BITS];
	assign result.out_end_col    = rng_w[0].e[COL_BITS-1:0];
	assign result.last_out       = (res_q == CNT_BITS'(1));
	assign result.any_merged     = merged;
	assign result.overflow       = ovf_q;

	`TRS_ASSERT_NOW(a_strobe_has_data, strobe, valid_w[0], "result strobed from an empty cell")
	`TRS_ASSERT_NEXT(a_last_frees, strobe && result.last_out, !busy, "busy after final result")
	`TRS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_BITS'(MAX_RANGES), "range count past row size")
	`TRS_ASSERT_NOW(a_emit_order, state_q == ST_EMIT && !result.last_out, valid_w[1],
		"row ran dry before the last result")

endmodule
